// File: rtl/can_frame_filter_buffer_packer_core_defines.svh
// assertion macros used by the checker file
`ifndef CAN_FRAME_FILTER_BUFFER_PACKER_CORE_DEFINES_SVH
`define CAN_FRAME_FILTER_BUFFER_PACKER_CORE_DEFINES_SVH

// implication in the same cycle
`define CFFBP_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("cffbp check failed");

// implication in the next cycle
`define CFFBP_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("cffbp check failed");

`endif

// File: rtl/cffbp_pkg.sv
// shared types and constants of the can frame filter, buffer and packer
package cffbp_pkg;

  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 11;
  localparam int ID_W        = 11;
  localparam int PKT_LEN     = 20;
  localparam int CRC_SPAN    = 18;
  localparam int CNT_W       = 5;

  // input tdata field offsets
  localparam int F_IDE_LSB     = 0;
  localparam int F_RTR_LSB     = 1;
  localparam int F_DLC_LSB     = 2;
  localparam int F_ID_LSB      = 6;
  localparam int F_PAYLOAD_LSB = 35;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_ACC_LOW   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACC_HIGH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACC_EXTRA = 2'd2;

  localparam logic [ID_W-1:0] ACC_LOW_RST   = 11'd193;
  localparam logic [ID_W-1:0] ACC_HIGH_RST  = 11'd203;
  localparam logic [ID_W-1:0] ACC_EXTRA_RST = 11'd26;

  localparam logic [7:0]  SYNC0    = 8'h55;
  localparam logic [7:0]  SYNC1    = 8'hAA;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  typedef enum logic [2:0] {
    ST_BYTE     = 3'd0,
    ST_ACCEPTED = 3'd1,
    ST_FULL     = 3'd2,
    ST_FILTERED = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic take;         // input item accepted this cycle
    logic load_status;  // put the latched status into the output register
    logic load_byte;    // put the current packet byte into the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pop_go;     // offered item is a pop on a non-empty ring
    logic out_free;   // output register can take a new item
    logic byte_last;  // current packet byte is the final one
  } stat_t;

endpackage

// File: rtl/cffbp_dp.sv
// datapath: config registers, filter, slot ring, packet bytes, crc, output register
module cffbp_dp import cffbp_pkg::*; #(
  parameter int SLOTS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic                   s_tuser,
  input  logic                   m_tready,
  output logic                   m_tvalid,
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic                   m_tlast,
  output logic [2:0]             m_tuser,
  input  cmd_t                   cmd,
  output stat_t                  stat
);

  localparam int PTR_W = $clog2(SLOTS);
  localparam int OCC_W = $clog2(SLOTS + 1);

  typedef struct packed {
    logic            rtr;
    logic [3:0]      dlc;
    logic [ID_W-1:0] id;
    logic [63:0]     payload;
  } slot_t;

  function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      r = r[15] ? ({r[14:0], 1'b0} ^ CRC_POLY) : {r[14:0], 1'b0};
    end
    return r;
  endfunction

  logic [ID_W-1:0]  acc_low, acc_high, acc_extra;
  slot_t            mem [SLOTS];
  slot_t            rd_data;
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [OCC_W-1:0] occ;
  logic [CNT_W-1:0] cnt;
  logic [15:0]      crc;
  status_t          status_q;
  status_t          push_status;
  logic [ID_W-1:0]  in_id;
  logic             in_match, in_full, do_store, do_pop;
  slot_t            in_slot;
  logic [7:0]       pkt [CRC_SPAN];
  logic [7:0]       cur_byte;

  // input fields
  assign in_id = s_tdata[F_ID_LSB +: ID_W];
  assign in_slot.rtr = s_tdata[F_RTR_LSB];
  assign in_slot.dlc = s_tdata[F_DLC_LSB +: 4];
  assign in_slot.id = in_id;
  assign in_slot.payload = s_tdata[F_PAYLOAD_LSB +: 64];

  assign in_full = (occ >= OCC_W'(SLOTS - 2));
  assign in_match = !s_tdata[F_IDE_LSB] &&
                    (((in_id >= acc_low) && (in_id <= acc_high)) || (in_id == acc_extra));

  always_comb begin
    if (in_full) begin
      push_status = ST_FULL;
    end else if (!in_match) begin
      push_status = ST_FILTERED;
    end else begin
      push_status = ST_ACCEPTED;
    end
  end

  assign do_store = cmd.take && (s_tuser == CMD_PUSH) && (push_status == ST_ACCEPTED);
  assign do_pop   = cmd.take && stat.pop_go;

  assign stat.pop_go    = (s_tuser == CMD_POP) && (occ != '0);
  assign stat.out_free  = !m_tvalid || m_tready;
  assign stat.byte_last = (cnt == CNT_W'(PKT_LEN - 1));

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_low   <= ACC_LOW_RST;
      acc_high  <= ACC_HIGH_RST;
      acc_extra <= ACC_EXTRA_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ACC_LOW:   acc_low   <= cfg_data;
        CFG_ACC_HIGH:  acc_high  <= cfg_data;
        CFG_ACC_EXTRA: acc_extra <= cfg_data;
        default: ;
      endcase
    end
  end

  // slot ring, one write and one registered read port
  always_ff @(posedge clk) begin
    if (do_store) begin
      mem[wr_ptr] <= in_slot;
    end
    if (do_pop) begin
      rd_data <= mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      occ    <= '0;
    end else begin
      if (do_store) begin
        wr_ptr <= (wr_ptr == PTR_W'(SLOTS - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(SLOTS - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_store) begin
        occ <= occ + 1'b1;
      end else if (do_pop) begin
        occ <= occ - 1'b1;
      end
    end
  end

  // packet bytes covered by the crc
  always_comb begin
    pkt[0]  = SYNC0;
    pkt[1]  = SYNC1;
    pkt[2]  = 8'h00;
    pkt[3]  = {7'd0, rd_data.rtr};
    pkt[4]  = {4'd0, rd_data.dlc};
    pkt[5]  = 8'h00;
    pkt[6]  = rd_data.id[7:0];
    pkt[7]  = {5'd0, rd_data.id[ID_W-1:8]};
    pkt[8]  = 8'h00;
    pkt[9]  = 8'h00;
    for (int i = 0; i < 8; i++) begin
      pkt[10 + i] = rd_data.payload[8*i +: 8];
    end
  end

  always_comb begin
    if (cnt < CNT_W'(CRC_SPAN)) begin
      cur_byte = pkt[cnt];
    end else if (cnt == CNT_W'(CRC_SPAN)) begin
      cur_byte = crc[7:0];
    end else begin
      cur_byte = crc[15:8];
    end
  end

  // byte counter, crc and latched status
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      cnt      <= '0;
      crc      <= CRC_INIT;
      status_q <= (s_tuser == CMD_POP) ? ST_EMPTY : push_status;
    end else if (cmd.load_byte) begin
      cnt <= cnt + 1'b1;
      if (cnt < CNT_W'(CRC_SPAN)) begin
        crc <= crc_step(crc, cur_byte);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_status || cmd.load_byte) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_status) begin
      m_tdata <= '0;
      m_tlast <= 1'b1;
      m_tuser <= status_q;
    end else if (cmd.load_byte) begin
      m_tdata <= cur_byte;
      m_tlast <= stat.byte_last;
      m_tuser <= ST_BYTE;
    end
  end

endmodule

// File: rtl/cffbp_ctrl.sv
// controller: sequences acceptance, status answers and packet emission
module cffbp_ctrl import cffbp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  s_tvalid,
  output logic  s_tready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [1:0] {
    IDLE,
    RESP,
    EMIT
  } state_t;

  state_t state;

  assign s_tready = (state == IDLE);

  always_comb begin
    cmd = '0;
    case (state)
      IDLE: cmd.take = s_tvalid;
      RESP: cmd.load_status = stat.out_free;
      EMIT: cmd.load_byte = stat.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      case (state)
        IDLE: begin
          if (s_tvalid) begin
            state <= stat.pop_go ? EMIT : RESP;
          end
        end
        RESP: begin
          if (stat.out_free) begin
            state <= IDLE;
          end
        end
        EMIT: begin
          if (stat.out_free && stat.byte_last) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// File: rtl/can_frame_filter_buffer_packer_core.sv
// top level of the can frame filter, buffer and packer
//
// input stream s_axis: one item per command; tuser selects push (0) or pop (1),
// tdata carries the received frame. a push filters the frame on its 11-bit
// standard identifier (range low..high, or the extra id; extended frames never
// pass), stores it in a ring of SLOTS entries unless SLOTS-2 are already held,
// and answers with one status item. a pop on a non-empty ring answers with the
// 20 packet bytes of the oldest frame (sync 55 aa, ide, rtr, dlc, 0, id as 4
// bytes, 8 data bytes, crc-16/ccitt-false low byte first), tlast on the last;
// on an empty ring it answers with one empty status item.
// the first result item goes into the output register once the sequencer has
// left idle. a pop emits its 20 bytes through the single output register,
// each as the register comes free, then returns to idle; a push emits its
// status item and returns to idle. one item at a time is worked on, but the
// next item is accepted while the final result still waits.
// the config port (cfg_we, cfg_index, cfg_data) writes the three id registers.
// reset (rst, synchronous) empties the ring and restores the id registers;
// slot contents are not cleared. a stalled receiver holds the output register
// and the sequencer simply waits, nothing is lost.
module can_frame_filter_buffer_packer_core import cffbp_pkg::*; #(
  parameter int SLOTS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  // config write port
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // input items
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // tdata: frame_ide, frame_rtr, frame_dlc[3:0], frame_id[28:0], frame_payload[63:0], pad
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // tuser: command
  input  logic                   s_axis_tuser,
  // result items
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // tdata: out_byte[7:0]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tlast,
  // tuser: status[2:0]
  output logic [2:0]             m_axis_tuser
);

  cmd_t  cmd;
  stat_t stat;

  // sequencer: idle -> status answer or byte emission -> idle
  cffbp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_axis_tvalid),
    .s_tready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // filter, ring storage, packet assembly, crc and output register
  cffbp_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_axis_tdata),
    .s_tuser   (s_axis_tuser),
    .m_tready  (m_axis_tready),
    .m_tvalid  (m_axis_tvalid),
    .m_tdata   (m_axis_tdata),
    .m_tlast   (m_axis_tlast),
    .m_tuser   (m_axis_tuser),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

// File: rtl/cffbp_checker.sv
// port-level checker for the can frame filter, buffer and packer, with its bind
`include "can_frame_filter_buffer_packer_core_defines.svh"

module cffbp_checker import cffbp_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   cfg_we,
  input logic [CFG_IDX_W-1:0]   cfg_index,
  input logic [CFG_DATA_W-1:0]  cfg_data,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input logic                   s_axis_tuser,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   m_axis_tlast,
  input logic [2:0]             m_axis_tuser
);

  logic                     s_fire, m_done;
  logic [1:0]               pend;
  logic                     unused_ok;
  logic                     out_stall, out_kept, status_item, status_clean, live;
  logic [OUT_TDATA_W+3:0]   out_last;

  assign s_fire = s_axis_tvalid && s_axis_tready;
  assign m_done = m_axis_tvalid && m_axis_tready && m_axis_tlast;
  assign unused_ok = cfg_we ^ (^cfg_index) ^ (^cfg_data) ^ (^s_axis_tdata) ^ s_axis_tuser;

  // previous output item, to see that a stalled item holds still
  always_ff @(posedge clk) begin
    out_last <= {m_axis_tdata, m_axis_tlast, m_axis_tuser};
  end

  assign out_stall    = m_axis_tvalid && !m_axis_tready;
  assign out_kept     = m_axis_tvalid &&
                        ({m_axis_tdata, m_axis_tlast, m_axis_tuser} == out_last);
  assign status_item  = m_axis_tvalid && (m_axis_tuser != ST_BYTE);
  assign status_clean = m_axis_tlast && (m_axis_tdata == '0) && (unused_ok || !unused_ok);
  assign live         = (pend != 2'd0) && (pend != 2'd3);

  // items accepted whose final result is not yet taken
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else begin
      pend <= pend + {1'b0, s_fire} - {1'b0, m_done};
    end
  end

  `CFFBP_ASSERT_NXT(a_out_hold, clk, rst, out_stall, out_kept)
  `CFFBP_ASSERT_IMP(a_status_alone, clk, rst, status_item, status_clean)
  `CFFBP_ASSERT_NXT(a_one_at_a_time, clk, rst, s_fire, !s_axis_tready)
  `CFFBP_ASSERT_IMP(a_no_invented, clk, rst, m_axis_tvalid, live)

endmodule

bind can_frame_filter_buffer_packer_core cffbp_checker u_cffbp_checker (.*);
